// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the text console character writer
// no dependencies

package tcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;
   localparam int CELL_W      = 16;

   localparam logic [7:0] CHR_NULL    = 8'd0;
   localparam logic [7:0] CHR_NEWLINE = 8'd10;
   localparam logic [7:0] CHR_SPACE   = 8'd32;

   typedef enum logic {
      ACT_PUT  = 1'b0,
      ACT_READ = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN
   } state_type;

   // packed with accepted in the lowest bit
   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic              scrolled;
      logic [6:0]        cursor_col;
      logic [4:0]        cursor_row;
      logic              accepted;
   } res_type;

endpackage

// ===== hdl/text_console_char_writer_top.sv =====
`timescale 1ns / 1ps
// text console character writer, top level
// depends on tcw_pkg and tcw_cell_ram

// A put word's result is registered in the output register, or in the skid
// register while the output stalls; a read word's cell passes the registered
// read port of the cell store before its result is registered. A put that runs
// past the last row copies rows 1 to ROWS-1 up by one through the single read
// and write port of the store, one cell a cycle, and no word is taken until the
// copy and its drain state are done. After reset a clearing pass writes every
// cell to zero, during which no word is taken. Results queue in an output register and a skid register.

module text_console_char_writer_top
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code, attribute, read_row, read_col
   input  logic [31:0] req_tdata,
   // action
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted, cursor_row, cursor_col, scrolled, cell_data
   output logic [31:0] rsp_tdata
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);

   localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0]    COLS_A    = AW'(COLUMNS);
   localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

   state_type state_ff, state_in;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     copy_dst_ff, copy_dst_in;
   logic              copy_pend_ff, copy_pend_in;
   logic              in_range_ff, in_range_in;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   res_type           out_ff, out_in;
   res_type           skid_ff, skid_in;

   logic [7:0]        char_code;
   logic [7:0]        attribute;
   logic [4:0]        read_row;
   logic [6:0]        read_col;
   logic              accept;
   logic              is_read;
   logic              put_wr;
   logic              scroll_go;
   logic              next_line;
   logic              rd_in_range;
   logic [AW-1:0]     rd_cell_addr;
   logic [AW-1:0]     cur_addr;
   logic              res_push;
   res_type           res;
   logic              pop;

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic [AW-1:0]     mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;

   assign char_code = req_tdata[7:0];
   assign attribute = req_tdata[15:8];
   assign read_row  = req_tdata[20:16];
   assign read_col  = req_tdata[27:21];

   assign req_tready = (state_ff == ST_IDLE) && !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign is_read    = (req_tuser == ACT_READ);

   assign rd_in_range  = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLUMNS));
   assign rd_cell_addr = AW'(32'(read_row) * 32'(COLUMNS) + 32'(read_col));
   assign cur_addr     = AW'(32'(row_ff) * 32'(COLUMNS) + 32'(col_ff));

   // cursor update for a put
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      put_wr    = 1'b0;
      scroll_go = 1'b0;
      next_line = 1'b0;
      if (accept && !is_read && char_code != CHR_NULL) begin
         put_wr    = (char_code != CHR_NEWLINE) && (char_code != CHR_SPACE);
         next_line = (char_code == CHR_NEWLINE) || (col_ff == COL_LAST);
         if (next_line) begin
            col_in = '0;
            if (row_ff == ROW_LAST) begin
               scroll_go = 1'b1;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && is_read) begin
               state_in = ST_READ;
            end else if (scroll_go) begin
               state_in = ST_SCROLL;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs of the sequencer: store ports, sweep address, result
   always_comb begin
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cur_addr;
      mem_wr_data  = {attribute, char_code};
      mem_rd_addr  = rd_cell_addr;
      addr_in      = addr_ff;
      copy_dst_in  = addr_ff - COLS_A;
      copy_pend_in = (state_ff == ST_SCROLL);
      in_range_in  = in_range_ff;
      res_push     = 1'b0;
      res.accepted   = 1'b0;
      res.cursor_row = 5'(row_in);
      res.cursor_col = 7'(col_in);
      res.scrolled   = scroll_go;
      res.cell_data  = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_ff;
            mem_wr_data = '0;
            addr_in     = addr_ff + AW'(1);
         end
         ST_IDLE: begin
            mem_wr_en = put_wr;
            if (accept) begin
               in_range_in  = rd_in_range;
               res_push     = !is_read;
               res.accepted = (char_code != CHR_NULL);
            end
            if (scroll_go) begin
               addr_in = COLS_A;
            end
         end
         ST_READ: begin
            res_push      = 1'b1;
            res.cell_data = in_range_ff ? mem_rd_data : '0;
         end
         ST_SCROLL: begin
            mem_wr_en   = copy_pend_ff;
            mem_wr_addr = copy_dst_ff;
            mem_wr_data = mem_rd_data;
            mem_rd_addr = addr_ff;
            addr_in     = addr_ff + AW'(1);
         end
         ST_DRAIN: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = copy_dst_ff;
            mem_wr_data = mem_rd_data;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // output register with skid stage
   assign pop = out_valid_ff && rsp_tready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && !pop) begin
         if (res_push) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_in       = res;
         skid_valid_in = res_push;
      end else begin
         out_in       = res;
         out_valid_in = res_push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         row_ff        <= '0;
         col_ff        <= '0;
         addr_ff       <= '0;
         copy_pend_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         addr_ff       <= addr_in;
         copy_pend_ff  <= copy_pend_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_dst_ff <= copy_dst_in;
      in_range_ff <= in_range_in;
      out_ff      <= out_in;
      skid_ff     <= skid_in;
   end

   tcw_cell_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = 32'(out_ff);

endmodule

// ===== hdl/tcw_cell_ram.sv =====
`timescale 1ns / 1ps
// text cell store: one write port, one read port with registered read data
// depends on tcw_pkg

module tcw_cell_ram
   import tcw_pkg::*;
#(
   parameter int DEPTH = DEF_ROWS * DEF_COLUMNS,
   parameter int AW    = $clog2(DEF_ROWS * DEF_COLUMNS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/text_console_char_writer_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for text_console_char_writer_top: put and read words, random gaps
// and stalls on both streams, results checked against a bench copy of the cells and cursor
// depends on tcw_pkg and text_console_char_writer_top

module text_console_char_writer_top_tb;
   import tcw_pkg::*;

   localparam int COLUMNS = DEF_COLUMNS;
   localparam int ROWS = DEF_ROWS;
   localparam int CLK_PERIOD = 10;
   localparam int RANDOM_WORDS = 1350;
   localparam longint WATCHDOG_CYCLES = 64'd20_000_000;

   typedef struct {
      action_type act;
      logic [7:0] chr;
      logic [7:0] attr;
      logic [4:0] row;
      logic [6:0] col;
      bit         hold;
   } console_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = ACT_PUT;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   logic [CELL_W-1:0] shadow_cells [ROWS*COLUMNS];
   int cur_row = 0;
   int cur_col = 0;

   console_word_type outgoing_words[$];
   console_word_type live_word;
   res_type          due_results[$];
   res_type          mon_want;
   res_type          mon_got;

   int send_wait = 0;
   int recv_wait = 0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;
   bit hold_next = 1'b0;
   int queued = 0;
   int fail_count = 0;
   int checked_count = 0;
   int put_count = 0;
   int null_count = 0;
   int read_count = 0;
   int wrap_count = 0;
   int scroll_count = 0;

   text_console_char_writer_top #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // applies one word to the bench copy of the console and returns its result
   function automatic res_type advance_console(console_word_type w);
      res_type r;
      bit      next_line;
      r = '0;
      if (w.act == ACT_READ) begin
         read_count++;
         if (w.row < ROWS && w.col < COLUMNS)
            r.cell_data = shadow_cells[w.row * COLUMNS + w.col];
      end else if (w.chr == CHR_NULL) begin
         null_count++;
      end else begin
         put_count++;
         r.accepted = 1'b1;
         if (w.chr != CHR_NEWLINE && w.chr != CHR_SPACE)
            shadow_cells[cur_row * COLUMNS + cur_col] = {w.attr, w.chr};
         next_line = (w.chr == CHR_NEWLINE);
         if (!next_line) begin
            cur_col++;
            if (cur_col >= COLUMNS) begin
               next_line = 1'b1;
               wrap_count++;
            end
         end
         if (next_line) begin
            cur_col = 0;
            // last row is left as it was
            if (cur_row + 1 >= ROWS) begin
               for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                  shadow_cells[i] = shadow_cells[i + COLUMNS];
               r.scrolled = 1'b1;
               scroll_count++;
            end else begin
               cur_row++;
            end
         end
      end
      r.cursor_row = 5'(cur_row);
      r.cursor_col = 7'(cur_col);
      return r;
   endfunction

   task automatic queue_word(action_type act, int chr, int attr, int row, int col);
      console_word_type w;
      w.act = act;
      w.chr = 8'(chr);
      w.attr = 8'(attr);
      w.row = 5'(row);
      w.col = 7'(col);
      w.hold = hold_next || ($urandom_range(0, 99) == 0);
      hold_next = 1'b0;
      outgoing_words.push_back(w);
      queued++;
   endtask

   task automatic put_char(int chr, int attr);
      queue_word(ACT_PUT, chr, attr, $urandom_range(0, 31), $urandom_range(0, 127));
   endtask

   task automatic read_cell(int row, int col);
      queue_word(ACT_READ, $urandom_range(0, 255), $urandom_range(0, 255), row, col);
   endtask

   function automatic int text_char();
      int p;
      p = $urandom_range(0, 99);
      if (p < 10)
         return CHR_SPACE;
      if (p < 16)
         return $urandom_range(1, 255);
      return $urandom_range(33, 126);
   endfunction

   task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= ACT_PUT;
      end else begin
         if (req_tvalid && req_tready) begin
            due_results.push_back(advance_console(live_word));
            send_wait = draw_gap(send_calm);
            if ($urandom_range(0, 63) == 0)
               send_calm = !send_calm;
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (outgoing_words.size() != 0 &&
                         !(outgoing_words[0].hold && due_results.size() != 0)) begin
               live_word = outgoing_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0, live_word.col, live_word.row, live_word.attr, live_word.chr};
               req_tuser <= live_word.act;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("result word with nothing expected: %h", rsp_tdata);
               fail_count++;
            end else begin
               mon_want = due_results.pop_front();
               mon_got = res_type'(rsp_tdata[29:0]);
               compare_field("accepted", 16'(mon_want.accepted), 16'(mon_got.accepted));
               compare_field("cursor_row", 16'(mon_want.cursor_row),
                             16'(mon_got.cursor_row));
               compare_field("cursor_col", 16'(mon_want.cursor_col),
                             16'(mon_got.cursor_col));
               compare_field("scrolled", 16'(mon_want.scrolled), 16'(mon_got.scrolled));
               compare_field("cell_data", mon_want.cell_data, mon_got.cell_data);
               compare_field("padding", 16'd0, 16'(rsp_tdata[31:30]));
               checked_count++;
            end
            recv_wait = draw_gap(recv_calm);
            if ($urandom_range(0, 63) == 0)
               recv_calm = !recv_calm;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int n;
      int pick;
      int target;
      for (int i = 0; i < ROWS * COLUMNS; i++)
         shadow_cells[i] = '0;

      // directed: cleared store, field extremes, null, space, newline, range edges
      read_cell(0, 0);
      put_char(CHR_NULL, 8'hFF);
      put_char(8'h41, 8'h00);
      put_char(8'hFF, 8'hFF);
      put_char(8'h01, 8'h80);
      put_char(CHR_SPACE, 8'h55);
      put_char(8'h7E, 8'h0F);
      put_char(CHR_NEWLINE, 8'hF0);
      put_char(8'hAA, 8'h55);
      put_char(CHR_NULL, 8'h00);
      for (int c = 0; c < 5; c++)
         read_cell(0, c);
      read_cell(1, 0);
      read_cell(1, 1);
      read_cell(ROWS - 1, COLUMNS - 1);
      read_cell(ROWS, 0);
      read_cell(0, COLUMNS);
      read_cell(31, 127);

      // random: text lines, some long enough to wrap, reads, newline runs and noise
      hold_next = 1'b1;
      target = queued + RANDOM_WORDS;
      while (queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
            repeat (n) put_char(text_char(), $urandom_range(0, 255));
            if ($urandom_range(0, 9) < 7)
               put_char(CHR_NEWLINE, $urandom_range(0, 255));
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 8)) begin
               n = $urandom_range(0, 9);
               if (n < 5)
                  read_cell($urandom_range(ROWS - 2, ROWS - 1), $urandom_range(0, COLUMNS - 1));
               else if (n < 9)
                  read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
               else
                  read_cell($urandom_range(0, 31), $urandom_range(0, 127));
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 5)) put_char(CHR_NEWLINE, $urandom_range(0, 255));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               n = ($urandom_range(0, 4) == 0) ? CHR_NULL : $urandom_range(0, 255);
               queue_word(action_type'($urandom_range(0, 1)), n, $urandom_range(0, 255),
                          $urandom_range(0, 31), $urandom_range(0, 127));
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (outgoing_words.size() != 0 || req_tvalid || due_results.size() != 0)
         @(negedge clock);
      // a stray result would need at most a scroll to appear
      repeat (ROWS * COLUMNS + 100) @(posedge clock);

      $display("ran %0d words: %0d puts taken, %0d nulls refused, %0d reads",
               queued, put_count, null_count, read_count);
      $display("%0d row-end wraps, %0d scrolls, %0d results checked, %0d errors",
               wrap_count, scroll_count, checked_count, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(WATCHDOG_CYCLES * CLK_PERIOD);
      $display("watchdog expired with %0d results outstanding", due_results.size());
      $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tcw_pkg.sv
hdl/tcw_cell_ram.sv
hdl/text_console_char_writer_top.sv
bench/text_console_char_writer_top_tb.sv
